// ===== rtl/rsc_pkg.sv =====
package rsc_pkg;

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int TAG_CNT_W = 3;
    localparam logic [TAG_CNT_W-1:0] TAGS_PER_LINE = 3'd6;

    localparam int STEP_W = 16;

    // ops per job: a tag plus line break is the widest case
    localparam int MAX_OPS  = 4;
    localparam int OP_IDX_W = 2;
    localparam int OP_CNT_W = 3;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd2;

    typedef enum logic [1:0] {
        OP_LIT,
        OP_ENC,
        OP_DEC
    } op_kind_t;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_LT,
        TAG_LT_E
    } tag_state_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] value;
    } op_t;

    typedef struct packed {
        op_t [MAX_OPS-1:0]   ops;
        logic [OP_CNT_W-1:0] count;
        logic                clear_step;
    } job_t;

    typedef struct packed {
        logic              decode_mode;
        logic [STEP_W-1:0] step_limit;
        logic              reverse_direction;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

endpackage

// ===== rtl/rsc_front.sv =====
module rsc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  rsc_pkg::cfg_t    cfg,
    input  logic             accept,
    input  rsc_pkg::in_item_t item,
    output logic             push,
    output rsc_pkg::job_t    job
);

    logic                               after_cr_reg;
    logic                               after_cr_next;
    logic [rsc_pkg::TAG_CNT_W-1:0]      tags_reg;
    logic [rsc_pkg::TAG_CNT_W-1:0]      tags_next;
    logic [rsc_pkg::TAG_CNT_W-1:0]      tags_inc;
    rsc_pkg::tag_state_t                tag_reg;
    rsc_pkg::tag_state_t                tag_next;
    logic [rsc_pkg::OP_CNT_W-1:0]       n;
    logic                               need_push;
    logic [7:0]                         b;

    assign b        = item.in_byte;
    assign tags_inc = tags_reg + 3'd1;

    always_comb
    begin
        job           = '0;
        n             = '0;
        need_push     = 1'b0;
        after_cr_next = after_cr_reg;
        tags_next     = tags_reg;
        tag_next      = tag_reg;

        if (item.is_end)
        begin
            need_push = 1'b1;
            if (!cfg.decode_mode)
            begin
                job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_LF};
                n = n + 3'd1;
            end
            else
            begin
                // flush a held partial tag byte by byte
                if (tag_reg != rsc_pkg::TAG_NONE)
                begin
                    job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_DEC, rsc_pkg::CH_LT};
                    n = n + 3'd1;
                end
                if (tag_reg == rsc_pkg::TAG_LT_E)
                begin
                    job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_DEC, rsc_pkg::CH_E};
                    n = n + 3'd1;
                end
            end
            job.clear_step = 1'b1;
            after_cr_next  = 1'b0;
            tags_next      = '0;
            tag_next       = rsc_pkg::TAG_NONE;
        end
        else if (!cfg.decode_mode)
        begin
            if (b == rsc_pkg::CH_LF && after_cr_reg)
            begin
                // second half of crlf, tag already sent
                after_cr_next = 1'b0;
            end
            else if (b == rsc_pkg::CH_CR || b == rsc_pkg::CH_LF)
            begin
                after_cr_next = (b == rsc_pkg::CH_CR);
                job.ops[0] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_LT};
                job.ops[1] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_E};
                job.ops[2] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_GT};
                n = 3'd3;
                if (tags_inc >= rsc_pkg::TAGS_PER_LINE)
                begin
                    job.ops[3] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_LF};
                    n = 3'd4;
                    tags_next = '0;
                end
                else
                begin
                    tags_next = tags_inc;
                end
                need_push = 1'b1;
            end
            else
            begin
                after_cr_next = 1'b0;
                job.ops[0] = '{rsc_pkg::OP_ENC, b};
                n = 3'd1;
                need_push = 1'b1;
            end
        end
        else
        begin
            if (tag_reg == rsc_pkg::TAG_LT && b == rsc_pkg::CH_E)
            begin
                tag_next = rsc_pkg::TAG_LT_E;
            end
            else if (tag_reg == rsc_pkg::TAG_LT_E && b == rsc_pkg::CH_GT)
            begin
                tag_next = rsc_pkg::TAG_NONE;
                job.ops[0] = '{rsc_pkg::OP_LIT, rsc_pkg::CH_LF};
                n = 3'd1;
                need_push = 1'b1;
            end
            else
            begin
                // broken tag: decipher held bytes, then take this byte afresh
                tag_next = rsc_pkg::TAG_NONE;
                if (tag_reg != rsc_pkg::TAG_NONE)
                begin
                    job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_DEC, rsc_pkg::CH_LT};
                    n = n + 3'd1;
                end
                if (tag_reg == rsc_pkg::TAG_LT_E)
                begin
                    job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_DEC, rsc_pkg::CH_E};
                    n = n + 3'd1;
                end
                if (b == rsc_pkg::CH_LT)
                begin
                    tag_next = rsc_pkg::TAG_LT;
                end
                else if (b != rsc_pkg::CH_CR && b != rsc_pkg::CH_LF)
                begin
                    job.ops[n[rsc_pkg::OP_IDX_W-1:0]] = '{rsc_pkg::OP_DEC, b};
                    n = n + 3'd1;
                end
                need_push = (n != '0);
            end
        end
        job.count = n;
    end

    assign push = accept && need_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_cr_reg <= 1'b0;
            tags_reg     <= '0;
            tag_reg      <= rsc_pkg::TAG_NONE;
        end
        else if (accept)
        begin
            after_cr_reg <= after_cr_next;
            tags_reg     <= tags_next;
            tag_reg      <= tag_next;
        end
    end

endmodule

// ===== rtl/rsc_queue.sv =====
module rsc_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  rsc_pkg::job_t                 push_job,
    input  logic                          pop,
    output rsc_pkg::job_t                 head,
    output logic [rsc_pkg::QUEUE_AW:0]    count,
    output logic                          full
);

    rsc_pkg::job_t                    entries [rsc_pkg::QUEUE_DEPTH];
    logic [rsc_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [rsc_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [rsc_pkg::QUEUE_AW:0]       count_reg;

    assign head  = entries[rd_ptr_reg];
    assign count = count_reg;
    assign full  = (count_reg == (rsc_pkg::QUEUE_AW+1)'(rsc_pkg::QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rsc_back.sv =====
module rsc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsc_pkg::cfg_t               cfg,
    input  logic                        head_valid,
    input  rsc_pkg::job_t               head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output rsc_pkg::out_item_t          out_data
);

    logic [rsc_pkg::OP_IDX_W-1:0]   idx_reg;
    logic [rsc_pkg::OP_IDX_W-1:0]   idx_next;
    logic [rsc_pkg::STEP_W-1:0]     step_reg;
    logic [rsc_pkg::STEP_W-1:0]     step_next;
    logic [rsc_pkg::STEP_W-1:0]     step_inc;
    logic [rsc_pkg::STEP_W-1:0]     step_new;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    rsc_pkg::out_item_t             out_data_reg;
    rsc_pkg::out_item_t             out_data_next;
    rsc_pkg::op_t                   op;
    logic                           out_free;
    logic                           advance;
    logic                           has_ops;
    logic                           last_op;
    logic                           emit;
    logic [7:0]                     mag;
    logic [7:0]                     add;
    logic                           neg;
    logic [7:0]                     coded;

    assign op       = head.ops[idx_reg];
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = head_valid && out_free;
    assign has_ops  = (head.count != '0);
    assign last_op  = (({1'b0, idx_reg} + 3'd1) == head.count);
    assign emit     = advance && has_ops;
    assign pop      = advance && (!has_ops || last_op);

    // step advances before each coded byte and wraps to one once it passes the limit
    assign step_inc = step_reg + 16'd1;
    assign step_new = (step_inc > cfg.step_limit) ? 16'd1 : step_inc;
    assign mag      = step_new[8:1] + {7'd0, step_new[0]};
    assign neg      = step_new[0] ^ cfg.reverse_direction ^ (op.kind == rsc_pkg::OP_ENC);
    assign add      = neg ? (8'd0 - mag) : mag;
    assign coded    = op.value + add;

    always_comb
    begin
        idx_next       = idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_free)
        begin
            out_valid_next = emit;
        end

        if (emit)
        begin
            out_data_next.out_byte    = (op.kind == rsc_pkg::OP_LIT) ? op.value : coded;
            out_data_next.last_of_run = last_op;
            idx_next = last_op ? '0 : idx_reg + 1'b1;
            if (op.kind != rsc_pkg::OP_LIT)
            begin
                step_next = step_new;
            end
        end

        // end of stream: fresh step count for the next stream
        if (pop && head.clear_step)
        begin
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/rolling_shift_text_codec.sv =====
// Rolling-shift text codec. Each input beat is classified up front and queued as a
// job of zero to four output bytes; the back end ciphers and sends one byte per cycle
// through a registered output unless out_stall holds it. A beat is accepted while its
// job fits in the four-entry job queue, so one-result beats run at one beat per cycle
// without output stall; a beat of more bytes (a tag with line break makes four) holds
// the output longer, and the queue absorbs the difference until it fills and in_stall
// rises. An end-of-stream beat with no byte still passes the queue to reset the step
// counter. Configuration is to be written through cfg_we while idle (not enforced).
module rolling_shift_text_codec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rsc_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rsc_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rsc_pkg::cfg_t                  cfg_reg;
    logic                           accept;
    logic                           push;
    rsc_pkg::job_t                  push_job;
    logic                           pop;
    rsc_pkg::job_t                  head;
    logic [rsc_pkg::QUEUE_AW:0]     q_count;
    logic                           q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decode_mode       <= 1'b1;
            cfg_reg.step_limit        <= 16'd6;
            cfg_reg.reverse_direction <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rsc_pkg::CFG_DECODE_MODE: cfg_reg.decode_mode       <= cfg_data[0];
                rsc_pkg::CFG_STEP_LIMIT:  cfg_reg.step_limit        <= cfg_data;
                rsc_pkg::CFG_REVERSE:     cfg_reg.reverse_direction <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    rsc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .item   (in_data),
        .push   (push),
        .job    (push_job)
    );

    rsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .count    (q_count),
        .full     (q_full)
    );

    rsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_count != '0),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= (rsc_pkg::QUEUE_AW+1)'(rsc_pkg::QUEUE_DEPTH))
        else $error("job queue over depth");

    // nothing is popped from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != '0))
        else $error("pop from empty job queue");

    // finishing a job with bytes leaves its final beat marked last
    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.count != '0) |=> (out_valid && out_data.last_of_run))
        else $error("job finished without last beat");
`endif

endmodule
